// ===== design/csw_pkg.sv =====
// Shared types and constants for the clock, stopwatch and countdown block.
`default_nettype none

package csw_pkg;

  // Counter limits
  localparam int MAX_SEC = 60;
  localparam int MAX_MIN = 60;
  localparam int MAX_HRS = 24;

  localparam logic [5:0] SEC_LAST = 6'(MAX_SEC - 1);
  localparam logic [5:0] MIN_LAST = 6'(MAX_MIN - 1);
  localparam logic [4:0] HRS_LAST = 5'(MAX_HRS - 1);

  // Mode switch codes
  typedef enum logic [3:0] {
    MODE_CLOCK       = 4'h1,
    MODE_WATCH       = 4'h2,
    MODE_DOWN        = 4'h4,
    MODE_CLOCK_SET   = 4'h9,
    MODE_WATCH_CLEAR = 4'hA,
    MODE_DOWN_SET    = 4'hC
  } mode_t;

  // Button bit positions within the level pair (active low)
  localparam int BTN_ZERO = 0;
  localparam int BTN_ONE  = 1;

  // Button levels after reset: button zero released, button one pressed
  localparam logic [1:0] LEVELS_RESET = 2'b01;

  // One input beat
  typedef struct packed {
    logic       second_tick;
    logic [3:0] mode;
    logic [1:0] button_levels;
  } item_t;

  // All counters, run flags and the last button levels
  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [5:0] watch_min;
    logic [5:0] watch_sec;
    logic       watch_run;
    logic [5:0] down_min;
    logic [5:0] down_sec;
    logic       down_run;
    logic [1:0] prev_levels;
  } state_t;

endpackage

`default_nettype wire

// ===== design/csw_in_stage.sv =====
// Input register stage: holds one accepted beat until the update stage takes it.
`default_nettype none

module csw_in_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire csw_pkg::item_t in_item,
  input  wire logic           take,
  output logic                q_valid,
  output csw_pkg::item_t      q_item
);

  logic load;

  // Accept a new beat when empty or when the held one leaves this cycle
  assign in_ready = !q_valid || take;
  assign load     = in_valid && in_ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else begin
      q_valid <= load || (q_valid && !take);
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (load) begin
      q_item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== design/csw_update.sv =====
// Next-state logic: applies the tick and then the button edges for one beat.
`default_nettype none

module csw_update (
  input  wire csw_pkg::state_t cur,
  input  wire csw_pkg::item_t  item,
  output csw_pkg::state_t      nxt
);

  logic [1:0] fell;

  always_comb begin
    nxt  = cur;
    // Falling edge: was released, now pressed
    fell = cur.prev_levels & ~item.button_levels;

    // Act on the one-second tick
    if (item.second_tick) begin
      case (item.mode)
        csw_pkg::MODE_CLOCK: begin
          if (cur.seconds >= csw_pkg::SEC_LAST) begin
            nxt.seconds = '0;
            if (cur.minutes >= csw_pkg::MIN_LAST) begin
              nxt.minutes = '0;
              nxt.hours   = (cur.hours >= csw_pkg::HRS_LAST) ? '0 : cur.hours + 5'd1;
            end else begin
              nxt.minutes = cur.minutes + 6'd1;
            end
          end else begin
            nxt.seconds = cur.seconds + 6'd1;
          end
        end
        csw_pkg::MODE_WATCH: begin
          if (cur.watch_run) begin
            if (cur.watch_sec >= csw_pkg::SEC_LAST) begin
              nxt.watch_sec = '0;
              nxt.watch_min = (cur.watch_min >= csw_pkg::MIN_LAST) ? '0
                                                                    : cur.watch_min + 6'd1;
            end else begin
              nxt.watch_sec = cur.watch_sec + 6'd1;
            end
          end
        end
        csw_pkg::MODE_DOWN: begin
          if (cur.down_min == '0 && cur.down_sec == '0) begin
            nxt.down_run = 1'b0;
          end else begin
            nxt.down_run = 1'b1;
            if (cur.down_sec == '0) begin
              nxt.down_sec = csw_pkg::SEC_LAST;
              nxt.down_min = cur.down_min - 6'd1;
            end else begin
              nxt.down_sec = cur.down_sec - 6'd1;
            end
          end
        end
        csw_pkg::MODE_WATCH_CLEAR: begin
          nxt.watch_min = '0;
          nxt.watch_sec = '0;
        end
        default: begin
        end
      endcase
    end

    // Button zero: step hours, timer minutes, or start the stopwatch
    if (fell[csw_pkg::BTN_ZERO]) begin
      case (item.mode)
        csw_pkg::MODE_CLOCK_SET: begin
          nxt.hours = (nxt.hours >= csw_pkg::HRS_LAST) ? '0 : nxt.hours + 5'd1;
        end
        csw_pkg::MODE_DOWN_SET: begin
          nxt.down_min = (nxt.down_min >= csw_pkg::MIN_LAST) ? '0 : nxt.down_min + 6'd1;
        end
        csw_pkg::MODE_WATCH: begin
          nxt.watch_run = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // Button one: step minutes, timer seconds, or stop the stopwatch
    if (fell[csw_pkg::BTN_ONE]) begin
      case (item.mode)
        csw_pkg::MODE_CLOCK_SET: begin
          nxt.minutes = (nxt.minutes >= csw_pkg::MIN_LAST) ? '0 : nxt.minutes + 6'd1;
        end
        csw_pkg::MODE_DOWN_SET: begin
          nxt.down_sec = (nxt.down_sec >= csw_pkg::SEC_LAST) ? '0 : nxt.down_sec + 6'd1;
        end
        csw_pkg::MODE_WATCH: begin
          nxt.watch_run = 1'b0;
        end
        default: begin
        end
      endcase
    end

    // Remember levels for the next beat
    nxt.prev_levels = item.button_levels;
  end

endmodule

`default_nettype wire

// ===== design/clock_stopwatch_countdown.sv =====
// Top level: input register, update logic and the state/result register.
//
//   channel | signals                               | carries
//   --------+---------------------------------------+------------------------------
//   in      | in_valid, in_ready                    | second_tick, mode, button_levels
//   out     | out_valid, out_ready                  | clock, stopwatch and timer counts
//
// Each beat is held in the input register and then updates the state register,
// which is also the result register. One beat per cycle is sustained while
// the result side is ready. The state update is the only loop, from the state
// register through the update logic back to it. Reset clears all counters and
// flags and sets the last button levels to 01. A stalled result holds the state;
// one further beat waits in the input register meanwhile.
`default_nettype none

module clock_stopwatch_countdown (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       second_tick,
  input  wire logic [3:0] mode,
  input  wire logic [1:0] button_levels,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [4:0]      clock_hours,
  output logic [5:0]      clock_minutes,
  output logic [5:0]      clock_seconds,
  output logic [5:0]      watch_minutes,
  output logic [5:0]      watch_seconds,
  output logic            watch_running,
  output logic [5:0]      countdown_minutes,
  output logic [5:0]      countdown_seconds,
  output logic            countdown_running
);

  csw_pkg::item_t  in_item;
  csw_pkg::item_t  q_item;
  logic            q_valid;
  logic            advance;
  csw_pkg::state_t state;
  csw_pkg::state_t state_next;

  assign in_item = '{second_tick: second_tick, mode: mode, button_levels: button_levels};

  csw_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (advance),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  // Move a beat into the result register when it is free or being drained
  assign advance = q_valid && (!out_valid || out_ready);

  csw_update u_update (
    .cur  (state),
    .item (q_item),
    .nxt  (state_next)
  );

  // Hold state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '{hours: '0, minutes: '0, seconds: '0, watch_min: '0, watch_sec: '0,
                     watch_run: 1'b0, down_min: '0, down_sec: '0, down_run: 1'b0,
                     prev_levels: csw_pkg::LEVELS_RESET};
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_next;
      end
      out_valid <= advance || (out_valid && !out_ready);
    end
  end

  // Drive the result beat from the state
  assign clock_hours       = state.hours;
  assign clock_minutes     = state.minutes;
  assign clock_seconds     = state.seconds;
  assign watch_minutes     = state.watch_min;
  assign watch_seconds     = state.watch_sec;
  assign watch_running     = state.watch_run;
  assign countdown_minutes = state.down_min;
  assign countdown_seconds = state.down_sec;
  assign countdown_running = state.down_run;

`ifndef SYNTHESIS
  // A beat that leaves the input register always shows up as a result
  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced beat produced no result");

  // The input register only stalls when it is full
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_valid)
    else $error("input refused while register empty");

  // The countdown only starts running on a timer-mode tick
  a_down_run_source: assert property (@(posedge clk) disable iff (rst)
    $rose(countdown_running) |->
      $past(advance && q_item.second_tick && q_item.mode == csw_pkg::MODE_DOWN))
    else $error("countdown started outside a timer tick");

  // Clock seconds move only on a clock-mode tick
  a_seconds_source: assert property (@(posedge clk) disable iff (rst)
    !$stable(clock_seconds) |->
      $past(rst) || $past(advance && q_item.second_tick && q_item.mode == csw_pkg::MODE_CLOCK))
    else $error("clock seconds changed without a clock tick");

  // Counters stay in range
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    clock_hours <= csw_pkg::HRS_LAST && clock_minutes <= csw_pkg::MIN_LAST &&
    clock_seconds <= csw_pkg::SEC_LAST && countdown_seconds <= csw_pkg::SEC_LAST)
    else $error("counter out of range");
`endif

endmodule

`default_nettype wire

// ===== test/clock_stopwatch_countdown_test.sv =====
// Self-checking testbench for the clock, stopwatch and countdown block.
`default_nettype none

module clock_stopwatch_countdown_test;

  // Mode codes that the block ignores
  localparam logic [3:0] MODE_UNUSED_LO = 4'h0;
  localparam logic [3:0] MODE_UNUSED_HI = 4'hF;

  // Button masks (set bit = pressed) and the all-released level pair
  localparam logic [1:0] PRESS_ZERO = 2'(1 << csw_pkg::BTN_ZERO);
  localparam logic [1:0] PRESS_ONE  = 2'(1 << csw_pkg::BTN_ONE);
  localparam logic [1:0] PRESS_BOTH = PRESS_ZERO | PRESS_ONE;
  localparam logic [1:0] RELEASED   = 2'b11;

  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PER_PHASE    = 380;
  localparam int WATCH_RUN    = 125;

  // Idle and stall percentages per phase
  localparam int SEND_IDLE [4]  = '{0, 82, 0, 23};
  localparam int TAKE_STALL [4] = '{0, 0, 82, 23};

  localparam logic [3:0] SET_MODES [3] = '{csw_pkg::MODE_CLOCK_SET, csw_pkg::MODE_DOWN_SET,
                                           csw_pkg::MODE_WATCH};
  localparam logic [3:0] RUN_MODES [4] = '{csw_pkg::MODE_CLOCK, csw_pkg::MODE_WATCH,
                                           csw_pkg::MODE_DOWN, csw_pkg::MODE_WATCH_CLEAR};

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [5:0] watch_min;
    logic [5:0] watch_sec;
    logic       watch_run;
    logic [5:0] down_min;
    logic [5:0] down_sec;
    logic       down_run;
  } reading_t;

  typedef struct packed {
    logic       tick;
    logic [3:0] sel;
    logic [1:0] levels;
    logic       pinned;
    reading_t   want;
  } script_row_t;

  // Directed walk: countdown set and run, clock set, stopwatch start and stop,
  // both buttons together, held buttons, ignored modes, field extremes
  localparam int SCRIPT_ROWS = 23;
  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    '{1'b0, MODE_UNUSED_LO,            2'b11, 1'b1, '0},
    '{1'b1, csw_pkg::MODE_DOWN,        2'b11, 1'b1, '0},
    '{1'b0, csw_pkg::MODE_DOWN_SET,    2'b10, 1'b1,
      '{5'd0, 6'd0, 6'd0, 6'd0, 6'd0, 1'b0, 6'd1, 6'd0, 1'b0}},
    '{1'b0, csw_pkg::MODE_DOWN_SET,    2'b00, 1'b1,
      '{5'd0, 6'd0, 6'd0, 6'd0, 6'd0, 1'b0, 6'd1, 6'd1, 1'b0}},
    '{1'b0, csw_pkg::MODE_DOWN_SET,    2'b00, 1'b0, '0},
    '{1'b0, csw_pkg::MODE_DOWN_SET,    2'b11, 1'b0, '0},
    '{1'b0, csw_pkg::MODE_DOWN_SET,    2'b00, 1'b0, '0},
    '{1'b1, csw_pkg::MODE_DOWN,        2'b11, 1'b0, '0},
    '{1'b1, csw_pkg::MODE_DOWN,        2'b11, 1'b0, '0},
    '{1'b1, csw_pkg::MODE_DOWN,        2'b11, 1'b0, '0},
    '{1'b0, csw_pkg::MODE_CLOCK_SET,   2'b10, 1'b0, '0},
    '{1'b0, csw_pkg::MODE_CLOCK_SET,   2'b00, 1'b0, '0},
    '{1'b1, csw_pkg::MODE_CLOCK_SET,   2'b11, 1'b0, '0},
    '{1'b1, csw_pkg::MODE_CLOCK,       2'b11, 1'b0, '0},
    '{1'b0, csw_pkg::MODE_WATCH,       2'b10, 1'b0, '0},
    '{1'b1, csw_pkg::MODE_WATCH,       2'b11, 1'b0, '0},
    '{1'b1, csw_pkg::MODE_WATCH,       2'b00, 1'b0, '0},
    '{1'b1, csw_pkg::MODE_WATCH,       2'b11, 1'b0, '0},
    '{1'b1, csw_pkg::MODE_WATCH_CLEAR, 2'b11, 1'b0, '0},
    '{1'b1, MODE_UNUSED_HI,            2'b00, 1'b0, '0},
    '{1'b0, csw_pkg::MODE_CLOCK,       2'b11, 1'b0, '0},
    '{1'b0, csw_pkg::MODE_CLOCK,       2'b10, 1'b0, '0},
    '{1'b1, MODE_UNUSED_LO,            2'b01, 1'b0, '0}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       second_tick = 1'b0;
  logic [3:0] mode = MODE_UNUSED_LO;
  logic [1:0] button_levels = RELEASED;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [4:0] clock_hours;
  logic [5:0] clock_minutes;
  logic [5:0] clock_seconds;
  logic [5:0] watch_minutes;
  logic [5:0] watch_seconds;
  logic       watch_running;
  logic [5:0] countdown_minutes;
  logic [5:0] countdown_seconds;
  logic       countdown_running;

  // Predicted block state
  logic [4:0] clk_hrs = '0;
  logic [5:0] clk_min = '0;
  logic [5:0] clk_sec = '0;
  logic [5:0] sw_min = '0;
  logic [5:0] sw_sec = '0;
  logic       sw_run = 1'b0;
  logic [5:0] cd_min = '0;
  logic [5:0] cd_sec = '0;
  logic       cd_run = 1'b0;
  logic [1:0] last_levels = csw_pkg::LEVELS_RESET;

  reading_t expected_readings [$];
  int send_idle_pct = 0;
  int take_stall_pct = 0;
  int failures = 0;
  int quiet_cycles = 0;
  int phase_passes = 0;

  clock_stopwatch_countdown u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .second_tick       (second_tick),
    .mode              (mode),
    .button_levels     (button_levels),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .clock_hours       (clock_hours),
    .clock_minutes     (clock_minutes),
    .clock_seconds     (clock_seconds),
    .watch_minutes     (watch_minutes),
    .watch_seconds     (watch_seconds),
    .watch_running     (watch_running),
    .countdown_minutes (countdown_minutes),
    .countdown_seconds (countdown_seconds),
    .countdown_running (countdown_running)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the predicted state by one pass and return the counters after it
  function automatic reading_t next_reading(input logic tick, input logic [3:0] sel,
                                            input logic [1:0] levels);
    logic [1:0] fell;
    fell = last_levels & ~levels;
    if (tick) begin
      case (sel)
        csw_pkg::MODE_CLOCK: begin
          if (clk_sec == csw_pkg::SEC_LAST) begin
            clk_sec = '0;
            if (clk_min == csw_pkg::MIN_LAST) begin
              clk_min = '0;
              clk_hrs = (clk_hrs == csw_pkg::HRS_LAST) ? '0 : clk_hrs + 5'd1;
            end else begin
              clk_min = clk_min + 6'd1;
            end
          end else begin
            clk_sec = clk_sec + 6'd1;
          end
        end
        csw_pkg::MODE_WATCH: begin
          if (sw_run) begin
            if (sw_sec == csw_pkg::SEC_LAST) begin
              sw_sec = '0;
              sw_min = (sw_min == csw_pkg::MIN_LAST) ? '0 : sw_min + 6'd1;
            end else begin
              sw_sec = sw_sec + 6'd1;
            end
          end
        end
        csw_pkg::MODE_DOWN: begin
          // arm, then count; the flag drops only on a tick taken at 0:00
          cd_run = 1'b1;
          if (cd_min == '0 && cd_sec == '0) begin
            cd_run = 1'b0;
          end else if (cd_sec == '0) begin
            cd_sec = csw_pkg::SEC_LAST;
            cd_min = cd_min - 6'd1;
          end else begin
            cd_sec = cd_sec - 6'd1;
          end
        end
        csw_pkg::MODE_WATCH_CLEAR: begin
          sw_min = '0;
          sw_sec = '0;
        end
        default: ;
      endcase
    end
    // button zero acts before button one
    if (fell[csw_pkg::BTN_ZERO]) begin
      case (sel)
        csw_pkg::MODE_CLOCK_SET: clk_hrs = (clk_hrs == csw_pkg::HRS_LAST) ? '0 : clk_hrs + 5'd1;
        csw_pkg::MODE_DOWN_SET:  cd_min = (cd_min == csw_pkg::MIN_LAST) ? '0 : cd_min + 6'd1;
        csw_pkg::MODE_WATCH:     sw_run = 1'b1;
        default: ;
      endcase
    end
    if (fell[csw_pkg::BTN_ONE]) begin
      case (sel)
        csw_pkg::MODE_CLOCK_SET: clk_min = (clk_min == csw_pkg::MIN_LAST) ? '0 : clk_min + 6'd1;
        csw_pkg::MODE_DOWN_SET:  cd_sec = (cd_sec == csw_pkg::SEC_LAST) ? '0 : cd_sec + 6'd1;
        csw_pkg::MODE_WATCH:     sw_run = 1'b0;
        default: ;
      endcase
    end
    last_levels = levels;
    return '{clk_hrs, clk_min, clk_sec, sw_min, sw_sec, sw_run, cd_min, cd_sec, cd_run};
  endfunction

  // Queue the expected reading and offer one beat; entered and left at a falling edge
  task automatic drive_pass(input logic tick, input logic [3:0] sel, input logic [1:0] levels,
                            input logic pinned = 1'b0, input reading_t pinned_value = '0);
    reading_t predicted;
    predicted = next_reading(tick, sel, levels);
    expected_readings.push_back(pinned ? pinned_value : predicted);
    if (sel inside {csw_pkg::MODE_CLOCK, csw_pkg::MODE_WATCH, csw_pkg::MODE_DOWN,
                    csw_pkg::MODE_CLOCK_SET, csw_pkg::MODE_WATCH_CLEAR,
                    csw_pkg::MODE_DOWN_SET}) begin
      phase_passes++;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    second_tick = tick;
    mode = sel;
    button_levels = levels;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Release, then press and release the masked buttons a number of times
  task automatic press_buttons(input logic [3:0] sel, input logic [1:0] mask, input int count);
    drive_pass(1'b0, sel, RELEASED);
    repeat (count) begin
      drive_pass($urandom_range(4) == 0, sel, ~mask);
      drive_pass($urandom_range(4) == 0, sel, RELEASED);
    end
  endtask

  task automatic random_sequence();
    case ($urandom_range(19))
      0, 1, 2, 3, 4: begin
        press_buttons(SET_MODES[$urandom_range(2)], 2'($urandom_range(1, 3)),
                      $urandom_range(1, 25));
      end
      5, 6, 7, 8, 9: begin
        logic [3:0] sel;
        sel = RUN_MODES[$urandom_range(3)];
        repeat ($urandom_range(1, 40)) begin
          drive_pass($urandom_range(9) != 0, sel,
                     ($urandom_range(3) != 0) ? RELEASED : 2'($urandom_range(3)));
        end
      end
      10: begin
        // set 23:59 and tick through midnight
        press_buttons(csw_pkg::MODE_CLOCK_SET, PRESS_ZERO, int'(csw_pkg::HRS_LAST - clk_hrs));
        press_buttons(csw_pkg::MODE_CLOCK_SET, PRESS_ONE, int'(csw_pkg::MIN_LAST - clk_min));
        repeat (csw_pkg::MAX_SEC - int'(clk_sec) + 1) begin
          drive_pass(1'b1, csw_pkg::MODE_CLOCK, RELEASED);
        end
      end
      11: begin
        // wrap the countdown minutes to zero, then run it out past 0:00
        press_buttons(csw_pkg::MODE_DOWN_SET, PRESS_ZERO,
                      (csw_pkg::MAX_MIN - int'(cd_min)) % csw_pkg::MAX_MIN);
        repeat (int'(cd_sec) + 2) drive_pass(1'b1, csw_pkg::MODE_DOWN, RELEASED);
      end
      12, 13: begin
        press_buttons(csw_pkg::MODE_WATCH, PRESS_ZERO, 1);
        repeat ($urandom_range(1, 70)) drive_pass(1'b1, csw_pkg::MODE_WATCH, RELEASED);
        press_buttons(csw_pkg::MODE_WATCH, PRESS_ONE, 1);
      end
      14, 15, 16, 17: begin
        repeat ($urandom_range(1, 10)) begin
          drive_pass(1'($urandom_range(1)), 4'($urandom_range(15)), 2'($urandom_range(3)));
        end
      end
      default: begin
        press_buttons(SET_MODES[$urandom_range(2)], PRESS_BOTH, $urandom_range(1, 3));
      end
    endcase
  endtask

  task automatic check_reading(input reading_t got, input reading_t want);
    if (got.hours != want.hours) begin
      $error("clock_hours: expected %0d, got %0d", want.hours, got.hours);
      failures++;
    end
    if (got.minutes != want.minutes) begin
      $error("clock_minutes: expected %0d, got %0d", want.minutes, got.minutes);
      failures++;
    end
    if (got.seconds != want.seconds) begin
      $error("clock_seconds: expected %0d, got %0d", want.seconds, got.seconds);
      failures++;
    end
    if (got.watch_min != want.watch_min) begin
      $error("watch_minutes: expected %0d, got %0d", want.watch_min, got.watch_min);
      failures++;
    end
    if (got.watch_sec != want.watch_sec) begin
      $error("watch_seconds: expected %0d, got %0d", want.watch_sec, got.watch_sec);
      failures++;
    end
    if (got.watch_run != want.watch_run) begin
      $error("watch_running: expected %0d, got %0d", want.watch_run, got.watch_run);
      failures++;
    end
    if (got.down_min != want.down_min) begin
      $error("countdown_minutes: expected %0d, got %0d", want.down_min, got.down_min);
      failures++;
    end
    if (got.down_sec != want.down_sec) begin
      $error("countdown_seconds: expected %0d, got %0d", want.down_sec, got.down_sec);
      failures++;
    end
    if (got.down_run != want.down_run) begin
      $error("countdown_running: expected %0d, got %0d", want.down_run, got.down_run);
      failures++;
    end
  endtask

  // Stall the result side at random
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= take_stall_pct);
  end

  // Check each result beat and watch for a hung handshake
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          $error("result beat with no expected reading waiting");
          failures++;
        end else begin
          check_reading({clock_hours, clock_minutes, clock_seconds, watch_minutes,
                         watch_seconds, watch_running, countdown_minutes,
                         countdown_seconds, countdown_running},
                        expected_readings.pop_front());
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("clock_stopwatch_countdown test failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed walk, no idling
    foreach (SCRIPT[i]) begin
      drive_pass(SCRIPT[i].tick, SCRIPT[i].sel, SCRIPT[i].levels, SCRIPT[i].pinned,
                 SCRIPT[i].want);
    end

    // Run the stopwatch past two minutes so the seconds wrap into the minutes
    press_buttons(csw_pkg::MODE_WATCH, PRESS_ZERO, 1);
    drive_pass(1'b1, csw_pkg::MODE_WATCH_CLEAR, RELEASED);
    repeat (WATCH_RUN) drive_pass(1'b1, csw_pkg::MODE_WATCH, {1'b1, 1'($urandom_range(1))});
    press_buttons(csw_pkg::MODE_WATCH, PRESS_ONE, 1);

    // Random sequences under each idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = SEND_IDLE[phase];
      take_stall_pct = TAKE_STALL[phase];
      phase_passes = 0;
      while (phase_passes < PER_PHASE) random_sequence();
    end

    // Drain the outstanding results
    in_valid = 1'b0;
    take_stall_pct = 0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("clock_stopwatch_countdown test passed");
    end else begin
      $display("clock_stopwatch_countdown test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
